/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also covers the reset period.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/jtk_pkg.sv */
package jtk_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int MAX_K     = 16;

    localparam int NODE_W  = 10;
    localparam int ADDR_W  = 12;
    localparam int VAL_W   = 13;
    localparam int CNT_W   = 13;
    localparam int UNI_W   = 14;
    localparam int SIM_W   = 17;
    localparam int RANK_W  = 5;
    localparam int KW_W    = 5;
    localparam int NC_W    = 11;
    localparam int RS_AW   = 11;
    localparam int KIDX_W  = 4;
    localparam int Q_FRAC  = 16;
    localparam int PROD_W  = CNT_W + UNI_W;
    localparam int HIST_DEPTH = 1 << NODE_W;

    localparam logic [1:0] OP_WR_ROW = 2'd0;
    localparam logic [1:0] OP_WR_NBR = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_RANKED = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BAD_K  = 2'd2;
    localparam logic [1:0] ST_WR_ACK = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] src_cnt;
        logic [CNT_W-1:0] cur_cnt;
    } hist_word_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [CNT_W-1:0]  inter;
        logic [UNI_W-1:0]  uni;
    } rank_entry_t;

    typedef struct packed {
        logic            clear;
        logic            insert;
        logic [KW_W-1:0] k_limit;
    } rank_ctrl_t;

    typedef struct packed {
        logic            busy;
        logic [KW_W-1:0] filled;
    } rank_stat_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [SIM_W-1:0]  sim;
        logic [CNT_W-1:0]  inter;
        logic [UNI_W-1:0]  uni;
        logic [RANK_W-1:0] rank;
        logic [1:0]        status;
        logic              last;
    } result_t;

endpackage

/* sv/jtk_graph.sv */
module jtk_graph (
    input  logic                       aclk,
    input  logic                       rs_we,
    input  logic [jtk_pkg::RS_AW-1:0]  rs_waddr,
    input  logic [jtk_pkg::VAL_W-1:0]  rs_wdata,
    input  logic [jtk_pkg::RS_AW-1:0]  rs_raddr,
    output logic [jtk_pkg::VAL_W-1:0]  rs_rdata,
    input  logic                       nb_we,
    input  logic [jtk_pkg::ADDR_W-1:0] nb_waddr,
    input  logic [jtk_pkg::NODE_W-1:0] nb_wdata,
    input  logic [jtk_pkg::ADDR_W-1:0] nb_raddr,
    output logic [jtk_pkg::NODE_W-1:0] nb_rdata
);
    import jtk_pkg::*;

    logic [VAL_W-1:0]  rs_mem [MAX_NODES+1];
    logic [NODE_W-1:0] nb_mem [MAX_EDGES];
    logic [VAL_W-1:0]  rs_rdata_reg;
    logic [NODE_W-1:0] nb_rdata_reg;

    always_ff @(posedge aclk) begin
        if (rs_we) begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        rs_rdata_reg <= rs_mem[rs_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nb_we) begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        nb_rdata_reg <= nb_mem[nb_raddr];
    end

    assign rs_rdata = rs_rdata_reg;
    assign nb_rdata = nb_rdata_reg;

endmodule

/* sv/jtk_hist.sv */
module jtk_hist (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [jtk_pkg::NODE_W-1:0] raddr,
    output jtk_pkg::hist_word_t        rdata,
    input  logic                       we,
    input  logic [jtk_pkg::NODE_W-1:0] waddr,
    input  jtk_pkg::hist_word_t        wdata,
    output logic                       clr_busy
);
    import jtk_pkg::*;

    hist_word_t        mem [HIST_DEPTH];
    hist_word_t        rdata_reg;
    logic              busy_reg;
    logic [NODE_W-1:0] cnt_reg;

    // After reset every count is swept to zero, one entry a cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == NODE_W'(HIST_DEPTH - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[cnt_reg] <= '0;
        end else if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata    = rdata_reg;
    assign clr_busy = busy_reg;

endmodule

/* sv/jtk_rank.sv */
module jtk_rank (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  jtk_pkg::rank_ctrl_t        ctrl,
    input  jtk_pkg::rank_entry_t       new_entry,
    input  logic [jtk_pkg::KIDX_W-1:0] rd_idx,
    output jtk_pkg::rank_entry_t       rd_entry,
    output jtk_pkg::rank_stat_t        stat
);
    import jtk_pkg::*;

    typedef enum logic [2:0] {R_IDLE, R_MUL, R_CMP, R_PLACE, R_SHIFT} rstate_t;

    rstate_t           state_reg;
    rank_entry_t       best_reg [MAX_K];
    rank_entry_t       new_reg;
    logic [KW_W-1:0]   filled_reg;
    logic [KW_W-1:0]   kw_reg;
    logic [KW_W-1:0]   pos_reg;
    logic [KW_W-1:0]   idx_reg;
    logic [PROD_W-1:0] prod_a_reg;
    logic [PROD_W-1:0] prod_b_reg;
    logic [KW_W-1:0]   idx_dec;
    logic [KIDX_W-1:0] sel;
    rank_entry_t       sel_entry;

    assign idx_dec = idx_reg - 1'b1;

    always_comb begin
        case (state_reg)
            R_MUL:   sel = pos_reg[KIDX_W-1:0];
            R_SHIFT: sel = idx_dec[KIDX_W-1:0];
            default: sel = rd_idx;
        endcase
    end

    assign sel_entry = best_reg[sel];

    // An entry with a ratio at least as high stays ahead of the new one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= R_IDLE;
            filled_reg <= '0;
            kw_reg     <= KW_W'(1);
        end else begin
            case (state_reg)
                R_IDLE: begin
                    if (ctrl.clear) begin
                        filled_reg <= '0;
                        kw_reg     <= ctrl.k_limit;
                    end else if (ctrl.insert) begin
                        new_reg   <= new_entry;
                        pos_reg   <= '0;
                        state_reg <= R_MUL;
                    end
                end
                R_MUL: begin
                    if (pos_reg >= filled_reg) begin
                        state_reg <= R_PLACE;
                    end else begin
                        prod_a_reg <= PROD_W'(sel_entry.inter) * PROD_W'(new_reg.uni);
                        prod_b_reg <= PROD_W'(new_reg.inter) * PROD_W'(sel_entry.uni);
                        state_reg  <= R_CMP;
                    end
                end
                R_CMP: begin
                    if (prod_a_reg >= prod_b_reg) begin
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= R_MUL;
                    end else begin
                        state_reg <= R_PLACE;
                    end
                end
                R_PLACE: begin
                    if (pos_reg >= kw_reg) begin
                        state_reg <= R_IDLE;
                    end else begin
                        idx_reg   <= (filled_reg < kw_reg) ? filled_reg : kw_reg - 1'b1;
                        state_reg <= R_SHIFT;
                    end
                end
                R_SHIFT: begin
                    if (idx_reg > pos_reg) begin
                        best_reg[idx_reg[KIDX_W-1:0]] <= sel_entry;
                        idx_reg <= idx_dec;
                    end else begin
                        best_reg[pos_reg[KIDX_W-1:0]] <= new_reg;
                        if (filled_reg < kw_reg) begin
                            filled_reg <= filled_reg + 1'b1;
                        end
                        state_reg <= R_IDLE;
                    end
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    assign rd_entry    = sel_entry;
    assign stat.busy   = (state_reg != R_IDLE);
    assign stat.filled = filled_reg;

endmodule

/* sv/jtk_div.sv */
module jtk_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [jtk_pkg::CNT_W-1:0] inter,
    input  logic [jtk_pkg::UNI_W-1:0] divisor,
    output logic                      done,
    output logic [jtk_pkg::SIM_W-1:0] quot
);
    import jtk_pkg::*;

    localparam int DIVD_W = CNT_W + Q_FRAC;
    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIVD_W-1:0] num_reg;
    logic [UNI_W-1:0]  rem_reg;
    logic [UNI_W-1:0]  div_reg;
    logic [UNI_W:0]    trial;
    logic              ge;

    // Restoring division, one quotient bit a cycle; quotient bits replace
    // the dividend bits as they shift out.
    assign trial = {rem_reg, num_reg[DIVD_W-1]};
    assign ge    = (trial >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVD_W);
                num_reg  <= {inter, {Q_FRAC{1'b0}}};
                rem_reg  <= '0;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg  <= ge ? UNI_W'(trial - {1'b0, div_reg}) : UNI_W'(trial);
                num_reg  <= {num_reg[DIVD_W-2:0], ge};
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg[SIM_W-1:0];

endmodule

/* sv/jaccard_top_k_graph_neighbors.sv */
// Writes: the acknowledge passes through the pending register to the output register; no item
// is taken while a result waits in the pending register. Query: each node's row bounds are read,
// each non-empty row is walked twice (count, then clear), the source row twice, and each insertion
// compares against each ranked entry it passes and moves later entries down; each result
// then waits on a division. Reset is synchronous, active low; afterwards a sweep zeroes the
// count memory and no item is taken until it ends. Configuration writes are taken throughout.
module jaccard_top_k_graph_neighbors (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [jtk_pkg::NC_W-1:0]   cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_opcode,
    input  logic [jtk_pkg::ADDR_W-1:0] s_address,
    input  logic [jtk_pkg::VAL_W-1:0]  s_value,
    input  logic [jtk_pkg::NODE_W-1:0] s_source_node,
    input  logic [jtk_pkg::KW_W-1:0]   s_k_wanted,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [jtk_pkg::NODE_W-1:0] m_neighbor_node,
    output logic [jtk_pkg::SIM_W-1:0]  m_similarity_q16,
    output logic [jtk_pkg::CNT_W-1:0]  m_intersection_count,
    output logic [jtk_pkg::UNI_W-1:0]  m_union_count,
    output logic [jtk_pkg::RANK_W-1:0] m_rank,
    output logic [1:0]                 m_status,
    output logic                       m_last
);
    import jtk_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE, T_RB0, T_RB1, T_RB2, T_E0, T_E1, T_E2, T_NODE,
        T_RANK, T_RANK_WAIT, T_OUT, T_DIV, T_DIV_WAIT, T_EMIT
    } tstate_t;

    typedef enum logic [1:0] {W_SRC, W_CUR, W_CLR_CUR, W_CLR_SRC} walk_t;

    tstate_t          state_reg;
    walk_t            mode_reg;
    logic [NC_W-1:0]  nc_reg;
    logic [NODE_W-1:0] source_reg;
    logic [NC_W-1:0]  node_reg;
    logic [VAL_W-1:0] start_reg;
    logic [VAL_W-1:0] len_reg;
    logic [VAL_W-1:0] src_start_reg;
    logic [VAL_W-1:0] src_len_reg;
    logic [VAL_W-1:0] ptr_reg;
    logic [VAL_W-1:0] cnt_reg;
    logic [NODE_W-1:0] v_reg;
    logic [CNT_W-1:0] inter_reg;
    logic [UNI_W-1:0] uni_reg;
    logic [KW_W-1:0]  ri_reg;
    logic             pend_valid_reg;
    result_t          pend_reg;
    logic             m_valid_reg;
    result_t          m_res_reg;

    logic              accept;
    logic              rs_we;
    logic              nb_we;
    logic [RS_AW-1:0]  rs_raddr;
    logic [VAL_W-1:0]  rs_rdata;
    logic [NODE_W-1:0] nb_rdata;
    hist_word_t        hist_rdata;
    hist_word_t        hist_wdata;
    logic              hist_we;
    logic              clr_busy;
    rank_ctrl_t        rank_ctrl;
    rank_entry_t       rank_new;
    rank_entry_t       rank_rd;
    rank_stat_t        rank_stat;
    logic              div_done;
    logic [SIM_W-1:0]  div_quot;
    logic [VAL_W-1:0]  bound_sat;
    logic [VAL_W-1:0]  row_len;
    logic [KW_W-1:0]   k_sat;
    logic              out_free;
    logic              ri_last;
    logic              pend_set;

    function automatic result_t flag_result(logic [1:0] st);
        result_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    assign s_ready  = (state_reg == T_IDLE) && !pend_valid_reg && !clr_busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign rs_we    = accept && (s_opcode == OP_WR_ROW) && (s_address <= ADDR_W'(MAX_NODES));
    assign nb_we    = accept && (s_opcode == OP_WR_NBR);
    assign rs_raddr = node_reg + RS_AW'(state_reg == T_RB1);

    assign bound_sat = (rs_rdata > VAL_W'(MAX_EDGES)) ? VAL_W'(MAX_EDGES) : rs_rdata;
    assign row_len   = (bound_sat > start_reg) ? bound_sat - start_reg : '0;
    assign k_sat     = (s_k_wanted > KW_W'(MAX_K)) ? KW_W'(MAX_K) : s_k_wanted;

    assign pend_set = (accept && (s_opcode == OP_WR_ROW || s_opcode == OP_WR_NBR))
                   || (accept && (s_opcode == OP_QUERY)
                       && (s_k_wanted == '0 || NC_W'(s_source_node) >= nc_reg))
                   || (state_reg == T_OUT && rank_stat.filled == '0 && !pend_valid_reg)
                   || (state_reg == T_EMIT && !pend_valid_reg);

    jtk_graph u_graph (
        .aclk     (aclk),
        .rs_we    (rs_we),
        .rs_waddr (s_address[RS_AW-1:0]),
        .rs_wdata (s_value),
        .rs_raddr (rs_raddr),
        .rs_rdata (rs_rdata),
        .nb_we    (nb_we),
        .nb_waddr (s_address),
        .nb_wdata (s_value[NODE_W-1:0]),
        .nb_raddr (ptr_reg[ADDR_W-1:0]),
        .nb_rdata (nb_rdata)
    );

    always_comb begin
        hist_we    = (state_reg == T_E2);
        hist_wdata = hist_rdata;
        case (mode_reg)
            W_SRC:     hist_wdata.src_cnt = hist_rdata.src_cnt + 1'b1;
            W_CUR:     hist_wdata.cur_cnt = hist_rdata.cur_cnt + 1'b1;
            W_CLR_CUR: hist_wdata.cur_cnt = '0;
            default:   hist_wdata = '0;
        endcase
    end

    jtk_hist u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .raddr    (nb_rdata),
        .rdata    (hist_rdata),
        .we       (hist_we),
        .waddr    (v_reg),
        .wdata    (hist_wdata),
        .clr_busy (clr_busy)
    );

    assign rank_ctrl.clear   = accept && (s_opcode == OP_QUERY);
    assign rank_ctrl.insert  = (state_reg == T_RANK);
    assign rank_ctrl.k_limit = k_sat;
    assign rank_new.node     = node_reg[NODE_W-1:0];
    assign rank_new.inter    = inter_reg;
    assign rank_new.uni      = uni_reg;

    jtk_rank u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rank_ctrl),
        .new_entry (rank_new),
        .rd_idx    (ri_reg[KIDX_W-1:0]),
        .rd_entry  (rank_rd),
        .stat      (rank_stat)
    );

    jtk_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == T_DIV),
        .inter   (rank_rd.inter),
        .divisor (rank_rd.uni),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign ri_last = ((ri_reg + 1'b1) == rank_stat.filled);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            mode_reg       <= W_SRC;
            nc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                nc_reg <= (cfg_wdata > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : cfg_wdata;
            end

            pend_valid_reg <= pend_set || (pend_valid_reg && !out_free);
            if (out_free) begin
                m_valid_reg <= pend_valid_reg;
                m_res_reg   <= pend_reg;
            end

            case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        if (s_opcode == OP_WR_ROW || s_opcode == OP_WR_NBR) begin
                            pend_reg <= flag_result(ST_WR_ACK);
                        end else if (s_opcode == OP_QUERY) begin
                            if (s_k_wanted == '0) begin
                                pend_reg <= flag_result(ST_BAD_K);
                            end else if (NC_W'(s_source_node) >= nc_reg) begin
                                pend_reg <= flag_result(ST_EMPTY);
                            end else begin
                                source_reg <= s_source_node;
                                node_reg   <= NC_W'(s_source_node);
                                mode_reg   <= W_SRC;
                                state_reg  <= T_RB0;
                            end
                        end
                    end
                end
                T_RB0: state_reg <= T_RB1;
                T_RB1: begin
                    start_reg <= bound_sat;
                    state_reg <= T_RB2;
                end
                T_RB2: begin
                    len_reg   <= row_len;
                    ptr_reg   <= start_reg;
                    cnt_reg   <= row_len;
                    inter_reg <= '0;
                    if (mode_reg == W_SRC) begin
                        src_start_reg <= start_reg;
                        src_len_reg   <= row_len;
                        state_reg     <= (row_len == '0) ? T_OUT : T_E0;
                    end else if (row_len == '0) begin
                        node_reg  <= node_reg + 1'b1;
                        state_reg <= T_NODE;
                    end else begin
                        state_reg <= T_E0;
                    end
                end
                T_E0: begin
                    if (cnt_reg != '0) begin
                        state_reg <= T_E1;
                    end else begin
                        case (mode_reg)
                            W_SRC: begin
                                node_reg  <= '0;
                                state_reg <= T_NODE;
                            end
                            W_CUR: begin
                                uni_reg   <= UNI_W'(src_len_reg) + UNI_W'(len_reg)
                                             - UNI_W'(inter_reg);
                                mode_reg  <= W_CLR_CUR;
                                ptr_reg   <= start_reg;
                                cnt_reg   <= len_reg;
                                state_reg <= T_E0;
                            end
                            W_CLR_CUR: begin
                                if (inter_reg != '0) begin
                                    state_reg <= T_RANK;
                                end else begin
                                    node_reg  <= node_reg + 1'b1;
                                    state_reg <= T_NODE;
                                end
                            end
                            default: state_reg <= T_OUT;
                        endcase
                    end
                end
                T_E1: begin
                    v_reg     <= nb_rdata;
                    state_reg <= T_E2;
                end
                T_E2: begin
                    if (mode_reg == W_CUR && hist_rdata.cur_cnt < hist_rdata.src_cnt) begin
                        inter_reg <= inter_reg + 1'b1;
                    end
                    ptr_reg   <= ptr_reg + 1'b1;
                    cnt_reg   <= cnt_reg - 1'b1;
                    state_reg <= T_E0;
                end
                T_NODE: begin
                    if (node_reg >= nc_reg) begin
                        mode_reg  <= W_CLR_SRC;
                        ptr_reg   <= src_start_reg;
                        cnt_reg   <= src_len_reg;
                        state_reg <= T_E0;
                    end else if (node_reg == NC_W'(source_reg)) begin
                        node_reg <= node_reg + 1'b1;
                    end else begin
                        mode_reg  <= W_CUR;
                        state_reg <= T_RB0;
                    end
                end
                T_RANK: state_reg <= T_RANK_WAIT;
                T_RANK_WAIT: begin
                    if (!rank_stat.busy) begin
                        node_reg  <= node_reg + 1'b1;
                        state_reg <= T_NODE;
                    end
                end
                T_OUT: begin
                    ri_reg <= '0;
                    if (rank_stat.filled != '0) begin
                        state_reg <= T_DIV;
                    end else if (!pend_valid_reg) begin
                        pend_reg  <= flag_result(ST_EMPTY);
                        state_reg <= T_IDLE;
                    end
                end
                T_DIV: state_reg <= T_DIV_WAIT;
                T_DIV_WAIT: begin
                    if (div_done) begin
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (!pend_valid_reg) begin
                        pend_reg.node   <= rank_rd.node;
                        pend_reg.sim    <= div_quot;
                        pend_reg.inter  <= rank_rd.inter;
                        pend_reg.uni    <= rank_rd.uni;
                        pend_reg.rank   <= ri_reg + 1'b1;
                        pend_reg.status <= ST_RANKED;
                        pend_reg.last   <= ri_last;
                        ri_reg          <= ri_reg + 1'b1;
                        state_reg       <= ri_last ? T_IDLE : T_DIV;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_neighbor_node      = m_res_reg.node;
    assign m_similarity_q16     = m_res_reg.sim;
    assign m_intersection_count = m_res_reg.inter;
    assign m_union_count        = m_res_reg.uni;
    assign m_rank               = m_res_reg.rank;
    assign m_status             = m_res_reg.status;
    assign m_last               = m_res_reg.last;

endmodule

/* sv/jtk_checker.sv */
`include "assert_macros.svh"

module jtk_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [jtk_pkg::NODE_W-1:0] m_neighbor_node,
    input logic [jtk_pkg::SIM_W-1:0]  m_similarity_q16,
    input logic [jtk_pkg::CNT_W-1:0]  m_intersection_count,
    input logic [jtk_pkg::UNI_W-1:0]  m_union_count,
    input logic [jtk_pkg::RANK_W-1:0] m_rank,
    input logic [1:0]                 m_status,
    input logic                       m_last
);
    import jtk_pkg::*;

    // A stalled result transfer keeps its node, rank, status and last flag.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_neighbor_node) && $stable(m_rank) && $stable(m_status) && $stable(m_last), "result changed while stalled")

    // Every result that is not a ranked entry stands alone and carries no rank.
    `ASSERT_CLK(a_single, aclk, aresetn, m_valid && m_status != ST_RANKED |-> m_last && m_rank == '0, "non-ranked result not single")

    // A ranked entry has a rank, shares at least one neighbour and has an intersection no larger than its union.
    `ASSERT_CLK(a_ranked, aclk, aresetn, m_valid && m_status == ST_RANKED |-> m_rank != '0 && m_intersection_count != '0 && m_intersection_count <= m_union_count, "ranked entry malformed")

    // Identical neighbour lists give a similarity of exactly one.
    `ASSERT_CLK(a_unity, aclk, aresetn, m_valid && m_status == ST_RANKED && m_intersection_count == m_union_count |-> m_similarity_q16 == SIM_W'(1 << Q_FRAC), "full overlap not one")

    // The count memory sweep holds off input transfers after reset.
    `ASSERT_CLK_ALWAYS(a_sweep, aclk, !aresetn |=> !s_ready, "input taken during sweep")

endmodule

bind jaccard_top_k_graph_neighbors jtk_checker u_jtk_checker (.*);
